/* rtl/wsfe_pkg.sv */
// ----------------------------------------------------------------------------
// wsfe_pkg - shared types and helpers for the WebSocket frame encoder
// Item layouts, queued job descriptor, opcode table and length helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsfe_pkg;

  // Width of the internal message and frame length counters (16..64)
  localparam int LEN_BITS = 32;

  // Job queue geometry (depth is a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Byte position counter inside one job (up to 14 header bytes plus payload)
  localparam int POS_W = 4;

  // Configuration register indexes
  localparam int CFG_W = 32;
  localparam logic [0:0] CFG_MASK_ENABLE   = 1'b0;
  localparam logic [0:0] CFG_MAX_FRAME_LEN = 1'b1;
  localparam logic [31:0] MAX_FRAME_RESET  = 32'd256;

  // Input item operations
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Message types
  localparam logic [1:0] TYPE_BINARY = 2'd0;
  localparam logic [1:0] TYPE_CLOSE  = 2'd1;
  localparam logic [1:0] TYPE_PING   = 2'd2;
  localparam logic [1:0] TYPE_PONG   = 2'd3;

  // Frame opcodes
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  // Length field codes
  localparam logic [6:0]  LEN7_MAX   = 7'd125;
  localparam logic [6:0]  LEN16_CODE = 7'd126;
  localparam logic [6:0]  LEN64_CODE = 7'd127;
  localparam logic [16:0] LEN16_MAX  = 17'h0FFFF;

  // Extended length byte counts
  localparam logic [POS_W-1:0] EXT_NONE = 4'd0;
  localparam logic [POS_W-1:0] EXT_16   = 4'd2;
  localparam logic [POS_W-1:0] EXT_64   = 4'd8;
  localparam logic [POS_W-1:0] KEY_LEN  = 4'd4;

  typedef logic [LEN_BITS-1:0] len_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  frame_type;
    logic [31:0] msg_len;
    logic [7:0]  payload_byte;
    logic [31:0] mask_key;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       frame_end;
    logic       message_end;
    logic       last_of_run;
  } out_item_t;

  // One queued unit of work: an optional header and an optional payload byte
  typedef struct packed {
    logic        hdr;
    logic        pay;
    logic        fin;
    logic [3:0]  opc;
    len_t        len;
    logic [31:0] key;
    logic [7:0]  data;
    logic        fe;
    logic        me;
  } job_t;

  function automatic logic [3:0] opcode_of(input logic [1:0] ftype);
    logic [3:0] opc;
    case (ftype)
      TYPE_BINARY: opc = OPC_BINARY;
      TYPE_CLOSE:  opc = OPC_CLOSE;
      TYPE_PING:   opc = OPC_PING;
      TYPE_PONG:   opc = OPC_PONG;
      default:     opc = OPC_BINARY;
    endcase
    return opc;
  endfunction

  // Clamp a 32-bit length to the counter width
  function automatic len_t sat_len(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    if ((w >> LEN_BITS) != 64'd0) return '1;
    return LEN_BITS'(w);
  endfunction

  // Key byte 0 is the most significant byte
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      2'd3:    b = key[7:0];
      default: b = key[31:24];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/wsfe_front.sv */
// ----------------------------------------------------------------------------
// wsfe_front - message tracker and item classifier
// Accepts input items and tracks message and frame counters; payload items
// of an open message and starts of empty messages become sequencer jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfe_front import wsfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire in_item_t    msg_item,
  input  wire logic        mask_enable,
  input  wire logic [31:0] max_frame_len,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic        active;
  logic [1:0]  msg_type;
  len_t        msg_remaining;
  len_t        frame_remaining;
  logic        first_frame;
  logic [31:0] frame_key;
  logic [1:0]  key_index;

  logic        accept;
  len_t        start_len;
  len_t        limit;
  len_t        flen;
  logic        new_frame;
  logic [31:0] key_eff;
  logic [1:0]  ki_eff;
  len_t        frem_eff;
  logic [7:0]  data_eff;

  assign msg_stall = q_full;
  assign accept    = msg_valid && !msg_stall;
  assign start_len = sat_len(msg_item.msg_len);

  // Size the frame that starts with this payload item
  always_comb begin
    if (msg_type == TYPE_BINARY) begin
      limit = sat_len(max_frame_len);
      if (limit == '0) begin
        limit = LEN_BITS'(1);
      end
    end else begin
      limit = msg_remaining;
    end
    flen      = (msg_remaining < limit) ? msg_remaining : limit;
    new_frame = (frame_remaining == '0);
    key_eff   = new_frame ? msg_item.mask_key : frame_key;
    ki_eff    = new_frame ? 2'd0 : key_index;
    frem_eff  = new_frame ? flen : frame_remaining;
    data_eff  = msg_item.payload_byte ^ (mask_enable ? key_byte(key_eff, ki_eff) : 8'h00);
  end

  // Build the job for the queue
  always_comb begin
    q_push = 1'b0;
    q_job  = '0;
    if (msg_item.op == OP_START) begin
      q_push    = accept && (start_len == '0);
      q_job.hdr = 1'b1;
      q_job.pay = 1'b0;
      q_job.fin = 1'b1;
      q_job.opc = opcode_of(msg_item.frame_type);
      q_job.len = '0;
      q_job.key = msg_item.mask_key;
      q_job.fe  = 1'b1;
      q_job.me  = 1'b1;
    end else begin
      q_push     = accept && active;
      q_job.hdr  = new_frame;
      q_job.pay  = 1'b1;
      q_job.fin  = (flen == msg_remaining);
      q_job.opc  = first_frame ? opcode_of(msg_type) : OPC_CONT;
      q_job.len  = flen;
      q_job.key  = key_eff;
      q_job.data = data_eff;
      q_job.fe   = (frem_eff == LEN_BITS'(1));
      q_job.me   = (msg_remaining == LEN_BITS'(1));
    end
  end

  // Advance message state
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      msg_type        <= TYPE_BINARY;
      msg_remaining   <= '0;
      frame_remaining <= '0;
      first_frame     <= 1'b1;
      frame_key       <= '0;
      key_index       <= 2'd0;
    end else if (accept) begin
      if (msg_item.op == OP_START) begin
        active          <= (start_len != '0);
        msg_type        <= msg_item.frame_type;
        msg_remaining   <= start_len;
        frame_remaining <= '0;
        first_frame     <= 1'b1;
        key_index       <= 2'd0;
        if (start_len == '0) begin
          frame_key <= msg_item.mask_key;
        end
      end else if (active) begin
        frame_key <= key_eff;
        key_index <= ki_eff + 2'd1;
        if (msg_remaining == LEN_BITS'(1)) begin
          active          <= 1'b0;
          first_frame     <= 1'b1;
          frame_remaining <= '0;
          msg_remaining   <= '0;
        end else begin
          first_frame     <= 1'b0;
          frame_remaining <= frem_eff - LEN_BITS'(1);
          msg_remaining   <= msg_remaining - LEN_BITS'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wsfe_queue.sv */
// ----------------------------------------------------------------------------
// wsfe_queue - small job queue between classifier and sequencer
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfe_queue import wsfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t               entries [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr;
  logic [Q_AW-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wsfe_back.sv */
// ----------------------------------------------------------------------------
// wsfe_back - byte sequencer
// Walks the job at the queue head, one byte per cycle when not stalled:
// header bytes, then the payload byte, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfe_back import wsfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic mask_enable,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      byte_valid,
  input  wire logic byte_stall,
  output out_item_t byte_item
);

  logic [POS_W-1:0] pos;

  logic             advance;
  logic [POS_W-1:0] ext_cnt;
  logic [POS_W-1:0] hdr_cnt;
  logic [POS_W-1:0] last_pos;
  logic             is_last;
  logic [6:0]       len_code;
  logic [63:0]      len64;
  logic [POS_W-1:0] ext_off;
  logic [POS_W-1:0] key_off;
  logic [2:0]       len_sel;
  logic [7:0]       byte_next;
  out_item_t        item_next;

  // Header layout of the current job
  always_comb begin
    len64 = 64'(head_job.len);
    if (head_job.len <= LEN_BITS'(LEN7_MAX)) begin
      ext_cnt  = EXT_NONE;
      len_code = head_job.len[6:0];
    end else if (head_job.len <= LEN_BITS'(LEN16_MAX)) begin
      ext_cnt  = EXT_16;
      len_code = LEN16_CODE;
    end else begin
      ext_cnt  = EXT_64;
      len_code = LEN64_CODE;
    end
    hdr_cnt  = head_job.hdr ? (POS_W'(2) + ext_cnt + (mask_enable ? KEY_LEN : '0)) : '0;
    last_pos = hdr_cnt + POS_W'(head_job.pay) - POS_W'(1);
    is_last  = (pos == last_pos);
    advance  = head_valid && (!byte_valid || !byte_stall);
    pop      = advance && is_last;
  end

  // Pick the byte at the current position
  always_comb begin
    ext_off = pos - POS_W'(2);
    key_off = ext_off - ext_cnt;
    len_sel = (ext_cnt == EXT_64) ? ext_off[2:0] : (ext_off[2:0] + 3'd6);
    if (pos >= hdr_cnt) begin
      byte_next = head_job.data;
    end else if (pos == POS_W'(0)) begin
      byte_next = {head_job.fin, 3'b000, head_job.opc};
    end else if (pos == POS_W'(1)) begin
      byte_next = {mask_enable, len_code};
    end else if (ext_off < ext_cnt) begin
      byte_next = len64[(3'd7 - len_sel) * 8 +: 8];
    end else begin
      byte_next = key_byte(head_job.key, key_off[1:0]);
    end
    item_next.out_byte    = byte_next;
    item_next.is_header   = (pos < hdr_cnt);
    item_next.frame_end   = is_last && head_job.fe;
    item_next.message_end = is_last && head_job.me;
    item_next.last_of_run = is_last;
  end

  // Step through the job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= is_last ? '0 : (pos + POS_W'(1));
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/websocket_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_encoder_core - WebSocket frame encoder, sending side
// Frames messages into header and (optionally masked) payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel msg_*: a start item (op 0) gives frame type and message
//   length; payload items (op 1) then carry one byte each. mask_key is taken
//   from the item on which a frame begins.
//   Output channel byte_*: one encoded byte per item, with header, frame end,
//   message end and end-of-run marks.
//   cfg_we/cfg_index/cfg_data write mask_enable (0) and max_frame_len (1)
//   while the block is idle.
// Timing:
//   The first byte caused by an item passes through the job queue and the
//   registered output stage before it is offered. The output stage sends
//   one byte per cycle unless the receiver stalls; a payload item inside a
//   frame yields one byte, one that opens a frame 2 to 14 header bytes and
//   its payload byte. A two-entry job queue lets the input run ahead.
// Reset clears the queue, the output stage and the message state, and loads
// mask_enable 0 and max_frame_len 256. When the receiver stalls, the output
// item holds, the queue fills and then msg_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_encoder_core import wsfe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             msg_valid,
  output logic                  msg_stall,
  input  wire in_item_t         msg_item,
  output logic                  byte_valid,
  input  wire logic             byte_stall,
  output out_item_t             byte_item,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic        mask_enable;
  logic [31:0] max_frame_len;

  logic        q_full;
  logic        q_push;
  job_t        q_job;
  logic        q_pop;
  logic        head_valid;
  job_t        head_job;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable   <= 1'b0;
      max_frame_len <= MAX_FRAME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_ENABLE:   mask_enable   <= cfg_data[0];
        CFG_MAX_FRAME_LEN: max_frame_len <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  wsfe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .msg_valid     (msg_valid),
    .msg_stall     (msg_stall),
    .msg_item      (msg_item),
    .mask_enable   (mask_enable),
    .max_frame_len (max_frame_len),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  wsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  wsfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mask_enable (mask_enable),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (q_pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item)
  );

endmodule

`default_nettype wire

/* rtl/wsfe_checker.sv */
// ----------------------------------------------------------------------------
// wsfe_checker - port-level checks for the frame encoder
// Watches the output channel for framing marks and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsfe_checker import wsfe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      byte_valid,
  input wire logic      byte_stall,
  input wire out_item_t byte_item
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("output item changed while stalled");

  // Come out of reset with no output item
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !byte_valid)
    else $error("output valid after reset");

  // End of message always closes the frame
  a_msg_closes_frame: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_item.message_end |-> byte_item.frame_end)
    else $error("message end without frame end");

  // Frame end and payload bytes finish the run of their input item
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    byte_valid && (byte_item.frame_end || !byte_item.is_header) |-> byte_item.last_of_run)
    else $error("frame end or payload byte not last of run");

endmodule

bind websocket_frame_encoder_core wsfe_checker u_wsfe_checker (.*);

`default_nettype wire

/* tb/sv/frame_byte_checker.sv */
// ----------------------------------------------------------------------------
// frame_byte_checker - scoreboard for the WebSocket frame encoder
// Watches the message, byte and register ports, rebuilds the expected
// encoded byte stream for each accepted item and compares it, field by
// field and in order, with the bytes the encoder hands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_byte_checker import wsfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  input  logic             msg_stall,
  input  in_item_t         msg_item,
  input  logic             byte_valid,
  input  logic             byte_stall,
  input  out_item_t        byte_item,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fails,
  output int               outstanding,
  output int               items_taken,
  output int               bytes_taken,
  output int               header_bytes
);

  localparam logic [63:0] SHORT_LEN_MAX = 64'd125;
  localparam logic [63:0] MID_LEN_MAX   = 64'h0000_0000_0000_FFFF;
  localparam logic [6:0]  LEN_CODE_16   = 7'd126;
  localparam logic [6:0]  LEN_CODE_64   = 7'd127;
  localparam len_t        LEN_LIMIT     = '1;

  // Register shadows
  logic        mask_on;
  logic [31:0] frame_cap;

  // Message state of the encoder as seen from outside
  logic        in_msg;
  logic [1:0]  cur_type;
  len_t        msg_left;
  len_t        frame_left;
  logic        opening;
  logic [31:0] frame_key;
  logic [1:0]  key_pos;

  out_item_t expected_bytes[$];

  function automatic len_t clamp_len(input logic [31:0] v);
    if (64'(v) > 64'(LEN_LIMIT)) return LEN_LIMIT;
    return len_t'(v);
  endfunction

  function automatic logic [3:0] opcode_for(input logic [1:0] ftype);
    logic [3:0] opc;
    case (ftype)
      TYPE_BINARY: opc = OPC_BINARY;
      TYPE_CLOSE:  opc = OPC_CLOSE;
      TYPE_PING:   opc = OPC_PING;
      default:     opc = OPC_PONG;
    endcase
    return opc;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic hdr, input logic fe,
                                   input logic me);
    out_item_t e;
    e.out_byte    = b;
    e.is_header   = hdr;
    e.frame_end   = fe;
    e.message_end = me;
    e.last_of_run = 1'b0;
    expected_bytes.insert(expected_bytes.size(), e);
  endfunction

  // Queue the header bytes of one frame: FIN/opcode, length form, key
  function automatic void add_header(input len_t flen, input logic fin,
                                     input logic [3:0] opc);
    logic [63:0] wide;
    wide = 64'(flen);
    add_byte({fin, 3'b000, opc}, 1'b1, 1'b0, 1'b0);
    if (wide <= SHORT_LEN_MAX) begin
      add_byte({mask_on, wide[6:0]}, 1'b1, 1'b0, 1'b0);
    end else if (wide <= MID_LEN_MAX) begin
      add_byte({mask_on, LEN_CODE_16}, 1'b1, 1'b0, 1'b0);
      add_byte(wide[15:8], 1'b1, 1'b0, 1'b0);
      add_byte(wide[7:0], 1'b1, 1'b0, 1'b0);
    end else begin
      add_byte({mask_on, LEN_CODE_64}, 1'b1, 1'b0, 1'b0);
      for (int i = 7; i >= 0; i--) add_byte(wide[8*i +: 8], 1'b1, 1'b0, 1'b0);
    end
    if (mask_on) begin
      for (int i = 3; i >= 0; i--) add_byte(frame_key[8*i +: 8], 1'b1, 1'b0, 1'b0);
    end
  endfunction

  // Work out the bytes that one accepted item causes
  function automatic void encode_item(input in_item_t it);
    int          first_new;
    len_t        limit;
    len_t        flen;
    logic [7:0]  b;
    first_new = expected_bytes.size();
    if (it.op == OP_START) begin
      // a start always drops whatever message was in progress
      in_msg     = 1'b1;
      cur_type   = it.frame_type;
      msg_left   = clamp_len(it.msg_len);
      frame_left = '0;
      opening    = 1'b1;
      key_pos    = '0;
      if (msg_left == '0) begin
        // empty message: whole header at once, key from the start item
        frame_key = it.mask_key;
        add_header('0, 1'b1, opcode_for(cur_type));
        in_msg = 1'b0;
        expected_bytes[expected_bytes.size()-1].frame_end   = 1'b1;
        expected_bytes[expected_bytes.size()-1].message_end = 1'b1;
      end
    end else if (in_msg) begin
      if (frame_left == '0) begin
        // open a frame; only binary messages get fragmented
        if (cur_type == TYPE_BINARY) begin
          limit = clamp_len(frame_cap);
          if (limit == '0) limit = len_t'(1);
        end else begin
          limit = msg_left;
        end
        flen      = (msg_left < limit) ? msg_left : limit;
        frame_key = it.mask_key;
        key_pos   = '0;
        add_header(flen, flen == msg_left, opening ? opcode_for(cur_type) : OPC_CONT);
        opening    = 1'b0;
        frame_left = flen;
      end
      b = it.payload_byte;
      if (mask_on) b = b ^ frame_key[24 - 8*key_pos +: 8];
      key_pos    = key_pos + 2'd1;
      frame_left = frame_left - len_t'(1);
      msg_left   = msg_left - len_t'(1);
      add_byte(b, 1'b0, frame_left == '0, msg_left == '0);
      if (msg_left == '0) begin
        in_msg     = 1'b0;
        opening    = 1'b1;
        frame_left = '0;
      end
    end
    if (expected_bytes.size() > first_new) begin
      expected_bytes[expected_bytes.size()-1].last_of_run = 1'b1;
    end
  endfunction

  task automatic report(input string msg);
    fails++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Compare one handed-out byte with the oldest expected one
  task automatic check_byte(input out_item_t got);
    out_item_t want;
    string     diffs;
    if (expected_bytes.size() == 0) begin
      report($sformatf("byte %02h arrived with nothing expected", got.out_byte));
      return;
    end
    want = expected_bytes[0];
    expected_bytes.delete(0);
    diffs = "";
    if (got.out_byte != want.out_byte)
      diffs = {diffs, $sformatf(" out_byte %02h/%02h", got.out_byte, want.out_byte)};
    if (got.is_header != want.is_header)
      diffs = {diffs, $sformatf(" is_header %0b/%0b", got.is_header, want.is_header)};
    if (got.frame_end != want.frame_end)
      diffs = {diffs, $sformatf(" frame_end %0b/%0b", got.frame_end, want.frame_end)};
    if (got.message_end != want.message_end)
      diffs = {diffs, $sformatf(" message_end %0b/%0b", got.message_end, want.message_end)};
    if (got.last_of_run != want.last_of_run)
      diffs = {diffs, $sformatf(" last_of_run %0b/%0b", got.last_of_run, want.last_of_run)};
    if (diffs != "") report($sformatf("byte #%0d got/want:%s", bytes_taken, diffs));
  endtask

  // Sample all ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      mask_on      = 1'b0;
      frame_cap    = 32'd256;
      in_msg       = 1'b0;
      cur_type     = TYPE_BINARY;
      msg_left     = '0;
      frame_left   = '0;
      opening      = 1'b1;
      frame_key    = '0;
      key_pos      = '0;
      fails        = 0;
      items_taken  = 0;
      bytes_taken  = 0;
      header_bytes = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MASK_ENABLE:   mask_on = cfg_data[0];
          CFG_MAX_FRAME_LEN: frame_cap = cfg_data[31:0];
          default: ;
        endcase
      end
      if (msg_valid && !msg_stall) begin
        items_taken++;
        encode_item(msg_item);
      end
      if (byte_valid && !byte_stall) begin
        bytes_taken++;
        if (byte_item.is_header) header_bytes++;
        check_byte(byte_item);
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for websocket_frame_encoder_core
// Drives directed and random messages (starts, payload bytes, stray bytes,
// dropped messages) under several mask and frame limit settings, with
// random idling on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import wsfe_pkg::*;;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int IDLE_PCT       = 13;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 128;
  localparam int PHASE_ITEMS    = 24;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             msg_valid = 1'b0;
  in_item_t         msg_item  = '0;
  logic             byte_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = CFG_MASK_ENABLE;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             msg_stall;
  logic             byte_valid;
  out_item_t        byte_item;

  // no idling on either side while calm is set
  logic calm = 1'b0;

  int fails;
  int outstanding;
  int items_taken;
  int bytes_taken;
  int header_bytes;

  int          counted_items  = 0;
  int          settings_used  = 0;
  logic        msg_open       = 1'b0;
  logic [31:0] bytes_left     = '0;

  always #HALF_PERIOD clk = ~clk;

  websocket_frame_encoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg_item   (msg_item),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frame_byte_checker byte_check (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg_item     (msg_item),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fails        (fails),
    .outstanding  (outstanding),
    .items_taken  (items_taken),
    .bytes_taken  (bytes_taken),
    .header_bytes (header_bytes)
  );

  // Stall the byte channel at random
  always @(negedge clk) begin
    byte_stall <= !rst && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((msg_valid && !msg_stall) || (byte_valid && !byte_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      msg_valid <= 1'b0;
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg_item  <= it;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_msg(input logic [1:0] ftype, input logic [31:0] len,
                           input logic [31:0] key);
    in_item_t it;
    it.op           = OP_START;
    it.frame_type   = ftype;
    it.msg_len      = len;
    it.payload_byte = 8'($urandom);
    it.mask_key     = key;
    send_item(it);
    counted_items++;
    msg_open   = (len != 0);
    bytes_left = len;
  endtask

  // Payload item; the fields it ignores carry random values
  task automatic send_byte(input logic [7:0] b, input logic [31:0] key);
    in_item_t it;
    it.op           = OP_PAYLOAD;
    it.frame_type   = 2'($urandom);
    it.msg_len      = $urandom;
    it.payload_byte = b;
    it.mask_key     = key;
    send_item(it);
    if (msg_open) begin
      counted_items++;
      bytes_left = bytes_left - 1;
      if (bytes_left == 0) msg_open = 1'b0;
    end
  endtask

  // Drain every expected byte, then give the encoder time to go quiet
  task automatic settle();
    msg_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic mask, input logic [31:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASK_ENABLE;
    cfg_data  <= CFG_W'(mask);
    @(negedge clk);
    cfg_index <= CFG_MAX_FRAME_LEN;
    cfg_data  <= CFG_W'(cap);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Mostly short well-formed messages; some huge or cut short
  task automatic random_message();
    logic [1:0]  ftype;
    logic [31:0] len;
    logic [31:0] body;
    int          pick;
    if ($urandom_range(99) < 55) ftype = TYPE_BINARY;
    else ftype = 2'($urandom_range(TYPE_CLOSE, TYPE_PONG));
    pick = $urandom_range(99);
    if (pick < 8) len = 0;
    else if (pick < 85) len = $urandom_range(1, 12);
    else if (pick < 93) len = $urandom_range(13, 300);
    else len = $urandom;
    body = len;
    if (len > 40) body = $urandom_range(1, 6);
    else if (len != 0 && $urandom_range(99) < 8) body = $urandom_range(0, len - 1);
    start_msg(ftype, len, $urandom);
    for (int i = 0; i < body; i++) send_byte(8'($urandom), $urandom);
  endtask

  initial begin
    int random_goal;
    int phase_goal;
    int phase;
    logic [31:0] cap;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: empty message, stray byte, short control message
    start_msg(TYPE_BINARY, 32'd0, 32'h0000_0000);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    start_msg(TYPE_PING, 32'd2, 32'h0000_0000);
    send_byte(8'h00, 32'h0000_0000);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    settle();

    // Masked, one byte per frame: fragmentation and continuation opcodes
    set_config(1'b1, 32'd1);
    start_msg(TYPE_BINARY, 32'd3, 32'h0000_0000);
    send_byte(8'h5A, 32'h1234_5678);
    send_byte(8'hC3, 32'h0000_0000);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    start_msg(TYPE_CLOSE, 32'd0, 32'hFFFF_FFFF);
    start_msg(TYPE_PONG, 32'd5, 32'h0123_4567);
    send_byte(8'h11, 32'h89AB_CDEF);
    send_byte(8'h22, 32'h0000_0000);
    settle();

    // Turn masking off in the middle of the open pong frame
    set_config(1'b0, 32'd1);
    send_byte(8'h33, 32'hFFFF_FFFF);
    settle();

    // Length form boundaries, the longest header, and dropped messages
    set_config(1'b1, 32'hFFFF_FFFF);
    start_msg(TYPE_BINARY, 32'hFFFF_FFFF, 32'hA1B2_C3D4);
    send_byte(8'hA5, 32'h0000_0000);
    start_msg(TYPE_PING, 32'd125, 32'hDEAD_BEEF);
    send_byte(8'h80, 32'h0000_0000);
    start_msg(TYPE_PONG, 32'd126, 32'h7F7F_7F7F);
    send_byte(8'h7F, 32'h0000_0000);
    start_msg(TYPE_BINARY, 32'd65535, 32'h8080_8080);
    send_byte(8'h01, 32'h0000_0000);
    start_msg(TYPE_CLOSE, 32'd65536, 32'hFFFF_FFFF);
    send_byte(8'hFE, 32'h0000_0000);
    settle();

    // Random phases, each under its own register setting
    random_goal = counted_items + RANDOM_ITEMS;
    phase = 0;
    while (counted_items < random_goal) begin
      case (phase % 6)
        0:       cap = 32'd1;
        1:       cap = 32'hFFFF_FFFF;
        2:       cap = $urandom_range(2, 8);
        3:       cap = 32'd3;
        4:       cap = $urandom_range(1, 20);
        default: cap = $urandom;
      endcase
      set_config(1'(phase % 2), cap);
      calm = (phase == 2);
      phase_goal = counted_items + PHASE_ITEMS;
      while (counted_items < phase_goal && counted_items < random_goal) begin
        if ($urandom_range(99) < 6) send_byte(8'($urandom), $urandom);
        else random_message();
      end
      settle();
      calm = 1'b0;
      phase++;
    end

    $display("Covered %0d items (%0d live) and %0d encoded bytes, %0d in headers.",
             items_taken, counted_items, bytes_taken, header_bytes);
    $display("Ran %0d register settings: masking on and off, frame limits 1 to 2^32-1.",
             settings_used);
    if (fails == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
